// File: src/topological_sort_engine_core_defines.svh
// -----------------------------------------------------------------------------
// Topological sort engine: assertion macros
// Shared concurrent check forms, clocked on clock and muted while reset is high.
// -----------------------------------------------------------------------------
`ifndef TOPOLOGICAL_SORT_ENGINE_CORE_DEFINES_SVH
`define TOPOLOGICAL_SORT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication
`define TSE_CHECK_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tse: same-cycle check failed");

// Next-cycle implication
`define TSE_CHECK_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tse: next-cycle check failed");

`endif

// File: src/tse_pkg.sv
// -----------------------------------------------------------------------------
// Topological sort engine package
// Default sizes, command codes and sequencer states.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tse_pkg;

   // Default sizes of the vertex and edge stores
   localparam int TSE_MAX_VERTICES = 64;
   localparam int TSE_MAX_EDGES    = 256;

   // Request commands
   typedef enum logic [0:0] {
      CMD_ADD_EDGE = 1'b0,
      CMD_SORT     = 1'b1
   } cmd_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_SEED,
      S_POP,
      S_HEAD_RD,
      S_HEAD,
      S_EDGE,
      S_TGT,
      S_DEC,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_WAIT
   } state_type;

endpackage

// File: src/topological_sort_engine_core.sv
// -----------------------------------------------------------------------------
// Topological sort engine (Kahn's algorithm)
// Request words (req_*) either add a directed edge or run a sort. Add-edge
// words give no response; an edge with a vertex at or above the vertex count,
// or arriving with the edge store full, is dropped and flagged. A sort word
// seeds a ready queue with the in-degree-zero vertices in ascending order,
// walks each popped vertex's edge list and returns the whole order (rsp_last
// on the final word) or a single cycle word, then empties the graph.
// csr_wr_en/csr_wr_data set the vertex count; write it only while idle.
// Steps: an add-edge word reads the head and in-degree, then writes back;
// a dropped word writes nothing back. A sort accepts, seeds each vertex in
// turn, reads each popped vertex's head, walks its edges one at a time, then
// emits each response word, waiting out any receiver stall; the single read
// port of the edge, head and in-degree memories sets this pacing.
// req_ready is low for the whole sort; a stalled response word simply holds.
// Reset empties the graph at once (valid bits, no clearing pass) and sets
// the vertex count to MAX_VERTICES.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "topological_sort_engine_core_defines.svh"

module topological_sort_engine_core
   import tse_pkg::*;
#(
   parameter int MAX_VERTICES = TSE_MAX_VERTICES,
   parameter int MAX_EDGES    = TSE_MAX_EDGES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [$clog2(MAX_VERTICES)-1:0]     req_source_vertex,
   input  logic [$clog2(MAX_VERTICES)-1:0]     req_target_vertex,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [$clog2(MAX_VERTICES)-1:0]     rsp_vertex,
   output logic                                rsp_last,
   output logic                                rsp_cycle_found,
   output logic                                rsp_bad_edge,
   input  logic                                csr_wr_en,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]   csr_wr_data
);

   localparam int VERT_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int EIDX_W  = $clog2(MAX_EDGES + 1);
   localparam int EADDR_W = $clog2(MAX_EDGES);
   localparam logic [CNT_W-1:0]  VMAX    = CNT_W'(MAX_VERTICES);
   localparam logic [EIDX_W-1:0] NO_EDGE = EIDX_W'(MAX_EDGES);

   // Control state
   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          vcount_ff, vcount_in;
   logic [EIDX_W-1:0]         edges_ff, edges_in;
   logic                      dropped_ff, dropped_in;
   logic [MAX_VERTICES-1:0]   head_valid_ff, head_valid_in;
   logic [MAX_VERTICES-1:0]   deg_valid_ff, deg_valid_in;
   logic [VERT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]          front_ff, front_in;
   logic [CNT_W-1:0]          rear_ff, rear_in;

   // Working registers
   logic [VERT_W-1:0]         node_ff, node_in;
   logic [VERT_W-1:0]         succ_ff, succ_in;
   logic [EIDX_W-1:0]         edge_ff, edge_in;
   logic                      cycle_ff, cycle_in;
   logic [VERT_W-1:0]         rsp_vertex_ff, rsp_vertex_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_cycle_ff, rsp_cycle_in;
   logic                      rsp_bad_ff, rsp_bad_in;

   // Memory ports
   logic                      head_we;
   logic [VERT_W-1:0]         head_waddr, head_raddr;
   logic [EIDX_W-1:0]         head_wdata, head_rdata;
   logic                      deg_we;
   logic [VERT_W-1:0]         deg_waddr, deg_raddr;
   logic [EIDX_W-1:0]         deg_wdata, deg_rdata;
   logic                      edge_we;
   logic [EADDR_W-1:0]        edge_waddr, edge_raddr;
   logic [VERT_W-1:0]         tgt_wdata, tgt_rdata;
   logic [EIDX_W-1:0]         link_wdata, link_rdata;
   logic                      q_we;
   logic [VERT_W-1:0]         q_waddr, q_raddr, q_wdata, q_rdata;

   // Derived values
   logic [CNT_W-1:0]          nv;
   logic [CNT_W-1:0]          nv_last;
   logic                      req_drop;
   logic [EIDX_W-1:0]         head_cur;
   logic [EIDX_W-1:0]         deg_cur;
   logic [EIDX_W-1:0]         deg_step;
   logic                      edge_live;
   logic                      pop_live;
   logic                      seed_hit;
   logic                      dec_push;
   logic                      graph_clear;

   // Clamp the vertex count to 1 .. MAX_VERTICES
   always_comb begin
      if (vcount_ff == '0) begin
         nv = CNT_W'(1);
      end else if (vcount_ff > VMAX) begin
         nv = VMAX;
      end else begin
         nv = vcount_ff;
      end
   end

   assign nv_last  = CNT_W'(nv - 1'b1);
   assign req_drop = (CNT_W'(req_source_vertex) >= nv) || (CNT_W'(req_target_vertex) >= nv)
                     || (edges_ff == NO_EDGE);

   // Invalid entries read as their cleared values
   assign head_cur = head_valid_ff[node_ff] ? head_rdata : NO_EDGE;
   assign deg_cur  = deg_valid_ff[succ_ff] ? deg_rdata : '0;

   // Shared in-degree step: increment on load, decrement on walk
   assign deg_step = deg_cur + ((state_ff == S_DEC) ? {EIDX_W{1'b1}} : EIDX_W'(1));

   assign edge_live = edge_ff < edges_ff;
   assign pop_live  = front_ff < rear_ff;
   assign seed_hit  = !deg_valid_ff[idx_ff];
   assign dec_push  = (deg_cur == EIDX_W'(1)) && (CNT_W'(succ_ff) < nv) && (rear_ff < nv);

   // Graph fully emptied
   assign graph_clear = (edges_ff == '0) && (head_valid_ff == '0) && (deg_valid_ff == '0)
                        && !dropped_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_SORT) begin
                  state_in = S_SEED;
               end else if (!req_drop) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD:    state_in = S_IDLE;
         S_SEED: begin
            if (CNT_W'(idx_ff) == nv_last) begin
               state_in = S_POP;
            end
         end
         S_POP:     state_in = pop_live ? S_HEAD_RD : S_EMIT_RD;
         S_HEAD_RD: state_in = S_HEAD;
         S_HEAD:    state_in = S_EDGE;
         S_EDGE:    state_in = edge_live ? S_TGT : S_POP;
         S_TGT:     state_in = S_DEC;
         S_DEC:     state_in = S_EDGE;
         S_EMIT_RD: state_in = S_EMIT_LD;
         S_EMIT_LD: state_in = S_EMIT_WAIT;
         S_EMIT_WAIT: begin
            if (rsp_ready) begin
               state_in = rsp_last_ff ? S_IDLE : S_EMIT_RD;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // Handshake and memory controls
   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      rsp_valid  = (state_ff == S_EMIT_WAIT);

      head_raddr = (state_ff == S_IDLE) ? req_source_vertex : q_rdata;
      deg_raddr  = (state_ff == S_IDLE) ? req_target_vertex : tgt_rdata;
      edge_raddr = edge_ff[EADDR_W-1:0];
      q_raddr    = (state_ff == S_POP) ? front_ff[VERT_W-1:0] : idx_ff;

      head_we    = (state_ff == S_LOAD);
      head_waddr = node_ff;
      head_wdata = edges_ff;

      edge_we    = (state_ff == S_LOAD);
      edge_waddr = edges_ff[EADDR_W-1:0];
      tgt_wdata  = succ_ff;
      link_wdata = head_cur;

      deg_we     = (state_ff == S_LOAD) || ((state_ff == S_DEC) && (deg_cur != '0));
      deg_waddr  = succ_ff;
      deg_wdata  = deg_step;

      q_we       = ((state_ff == S_SEED) && seed_hit) || ((state_ff == S_DEC) && dec_push);
      q_waddr    = rear_ff[VERT_W-1:0];
      q_wdata    = (state_ff == S_SEED) ? idx_ff : succ_ff;
   end

   // Datapath next values
   always_comb begin
      vcount_in     = vcount_ff;
      edges_in      = edges_ff;
      dropped_in    = dropped_ff;
      head_valid_in = head_valid_ff;
      deg_valid_in  = deg_valid_ff;
      idx_in        = idx_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      node_in       = node_ff;
      succ_in       = succ_ff;
      edge_in       = edge_ff;
      cycle_in      = cycle_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_cycle_in  = rsp_cycle_ff;
      rsp_bad_in    = rsp_bad_ff;

      if (csr_wr_en) begin
         vcount_in = csr_wr_data;
      end

      // Advance the queue tail on every push
      if (q_we) begin
         rear_in = CNT_W'(rear_ff + 1'b1);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               node_in = req_source_vertex;
               succ_in = req_target_vertex;
               if (req_command == CMD_SORT) begin
                  idx_in   = '0;
                  front_in = '0;
                  rear_in  = '0;
               end else if (req_drop) begin
                  dropped_in = 1'b1;
               end
            end
         end
         S_LOAD: begin
            edges_in               = EIDX_W'(edges_ff + 1'b1);
            head_valid_in[node_ff] = 1'b1;
            deg_valid_in[succ_ff]  = 1'b1;
         end
         S_SEED: begin
            idx_in = VERT_W'(idx_ff + 1'b1);
         end
         S_POP: begin
            if (pop_live) begin
               front_in = CNT_W'(front_ff + 1'b1);
            end else begin
               idx_in   = '0;
               cycle_in = (rear_ff != nv);
            end
         end
         S_HEAD_RD: begin
            node_in = q_rdata;
         end
         S_HEAD: begin
            edge_in = head_cur;
         end
         S_TGT: begin
            succ_in = tgt_rdata;
            edge_in = link_rdata;
         end
         S_EMIT_LD: begin
            rsp_vertex_in = cycle_ff ? '0 : q_rdata;
            rsp_last_in   = cycle_ff || (CNT_W'(idx_ff) == nv_last);
            rsp_cycle_in  = cycle_ff;
            rsp_bad_in    = dropped_ff;
         end
         S_EMIT_WAIT: begin
            if (rsp_ready) begin
               if (rsp_last_ff) begin
                  // Drop the whole graph after the final word
                  edges_in      = '0;
                  dropped_in    = 1'b0;
                  head_valid_in = '0;
                  deg_valid_in  = '0;
               end else begin
                  idx_in = VERT_W'(idx_ff + 1'b1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         vcount_ff     <= VMAX;
         edges_ff      <= '0;
         dropped_ff    <= 1'b0;
         head_valid_ff <= '0;
         deg_valid_ff  <= '0;
         idx_ff        <= '0;
         front_ff      <= '0;
         rear_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         vcount_ff     <= vcount_in;
         edges_ff      <= edges_in;
         dropped_ff    <= dropped_in;
         head_valid_ff <= head_valid_in;
         deg_valid_ff  <= deg_valid_in;
         idx_ff        <= idx_in;
         front_ff      <= front_in;
         rear_ff       <= rear_in;
      end
   end

   // Working and response registers
   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      succ_ff       <= succ_in;
      edge_ff       <= edge_in;
      cycle_ff      <= cycle_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_cycle_ff  <= rsp_cycle_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_vertex      = rsp_vertex_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_cycle_found = rsp_cycle_ff;
   assign rsp_bad_edge    = rsp_bad_ff;

   // List heads per source vertex
   tse_ram #(.WIDTH(EIDX_W), .DEPTH(MAX_VERTICES)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   // In-degree per vertex
   tse_ram #(.WIDTH(EIDX_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_we),
      .wr_addr (deg_waddr),
      .wr_data (deg_wdata),
      .rd_addr (deg_raddr),
      .rd_data (deg_rdata)
   );

   // Edge targets
   tse_ram #(.WIDTH(VERT_W), .DEPTH(MAX_EDGES)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (tgt_wdata),
      .rd_addr (edge_raddr),
      .rd_data (tgt_rdata)
   );

   // Edge links, newest first
   tse_ram #(.WIDTH(EIDX_W), .DEPTH(MAX_EDGES)) u_link_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (link_wdata),
      .rd_addr (edge_raddr),
      .rd_data (link_rdata)
   );

   // Ready queue, which also holds the finished order
   tse_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   // Checks
   `TSE_CHECK_IMP(a_front_le_rear, 1'b1, front_ff <= rear_ff)
   `TSE_CHECK_IMP(a_rear_bound, 1'b1, rear_ff <= VMAX)
   `TSE_CHECK_IMP(a_edge_bound, 1'b1, edges_ff <= NO_EDGE)
   `TSE_CHECK_IMP(a_cycle_word, rsp_valid && rsp_cycle_found, rsp_last && (rsp_vertex == '0))
   `TSE_CHECK_NXT(a_clear_after_sort, rsp_valid && rsp_ready && rsp_last, (state_ff == S_IDLE) && graph_clear)

endmodule

// File: src/tse_ram.sv
// -----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
